// File: rtl/fmn_pkg.sv
`timescale 1ns / 1ps
package fmn_pkg;

   localparam int FMN_LOG_BITS = 16;

   localparam int FREQ_W  = 32;
   localparam int REF_W   = 25;
   localparam int MANT_W  = 32;
   localparam int POS_W   = $clog2(MANT_W);
   localparam int EXP_W   = POS_W + 2;

   localparam int MIDI_W  = 9;
   localparam int IDX_W   = 4;
   localparam int OCT_W   = 6;
   localparam int CENTS_W = 14;

   localparam logic [REF_W-1:0] REF_RESET = 25'd28835840;

   typedef struct packed {
      logic valid;
      logic zero;
   } fmn_ctl_type;

endpackage

// File: rtl/fmn_req_if.sv
`timescale 1ns / 1ps
interface fmn_req_if import fmn_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] freq_q16;

   modport source (output valid, output freq_q16, input ready);
   modport sink   (input valid, input freq_q16, output ready);
endinterface

// File: rtl/fmn_rsp_if.sv
`timescale 1ns / 1ps
interface fmn_rsp_if import fmn_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      note_valid;
   logic signed [MIDI_W-1:0]  midi_note;
   logic [IDX_W-1:0]          pitch_class;
   logic signed [OCT_W-1:0]   octave_number;
   logic signed [CENTS_W-1:0] cents_deviation;

   modport source (output valid, output note_valid, output midi_note, output pitch_class,
                   output octave_number, output cents_deviation, input ready);
   modport sink   (input valid, input note_valid, input midi_note, input pitch_class,
                   input octave_number, input cents_deviation, output ready);
endinterface

// File: rtl/fmn_normalize.sv
`timescale 1ns / 1ps
module fmn_normalize import fmn_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    up_valid,
   input  logic [FREQ_W-1:0]       up_freq,
   input  logic [REF_W-1:0]        up_a4,
   output fmn_ctl_type             dn_ctl,
   output logic signed [EXP_W-1:0] dn_exp,
   output logic [MANT_W-1:0]       dn_mant_f,
   output logic [MANT_W-1:0]       dn_mant_r
);

   function automatic logic [POS_W-1:0] lead_one(input logic [MANT_W-1:0] x);
      logic [POS_W-1:0] p;
      p = '0;
      for (int i = 0; i < MANT_W; i++) begin
         if (x[i]) begin
            p = POS_W'(i);
         end
      end
      return p;
   endfunction

   logic [MANT_W-1:0]       a4_wide;
   logic [POS_W-1:0]        pos_f;
   logic [POS_W-1:0]        pos_r;
   fmn_ctl_type             ctl_in;
   fmn_ctl_type             ctl_ff;
   logic signed [EXP_W-1:0] exp_in;
   logic signed [EXP_W-1:0] exp_ff;
   logic [MANT_W-1:0]       mant_f_in;
   logic [MANT_W-1:0]       mant_f_ff;
   logic [MANT_W-1:0]       mant_r_in;
   logic [MANT_W-1:0]       mant_r_ff;

   always_comb begin
      a4_wide      = MANT_W'(up_a4);
      pos_f        = lead_one(up_freq);
      pos_r        = lead_one(a4_wide);
      ctl_in.valid = up_valid;
      ctl_in.zero  = (up_freq == '0) || (up_a4 == '0);
      exp_in       = $signed({2'b00, pos_f}) - $signed({2'b00, pos_r});
      mant_f_in    = up_freq << (POS_W'(MANT_W - 1) - pos_f);
      mant_r_in    = a4_wide << (POS_W'(MANT_W - 1) - pos_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exp_ff    <= exp_in;
         mant_f_ff <= mant_f_in;
         mant_r_ff <= mant_r_in;
      end
   end

   assign dn_ctl    = ctl_ff;
   assign dn_exp    = exp_ff;
   assign dn_mant_f = mant_f_ff;
   assign dn_mant_r = mant_r_ff;

endmodule

// File: rtl/fmn_log_stage.sv
`timescale 1ns / 1ps
module fmn_log_stage import fmn_pkg::*; #(
   parameter int LOG_BITS = FMN_LOG_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  fmn_ctl_type             up_ctl,
   input  logic signed [EXP_W-1:0] up_exp,
   input  logic [MANT_W-1:0]       up_mant_f,
   input  logic [MANT_W-1:0]       up_mant_r,
   input  logic [LOG_BITS-1:0]     up_frac_f,
   input  logic [LOG_BITS-1:0]     up_frac_r,
   output fmn_ctl_type             dn_ctl,
   output logic signed [EXP_W-1:0] dn_exp,
   output logic [MANT_W-1:0]       dn_mant_f,
   output logic [MANT_W-1:0]       dn_mant_r,
   output logic [LOG_BITS-1:0]     dn_frac_f,
   output logic [LOG_BITS-1:0]     dn_frac_r
);

   logic [2*MANT_W-1:0]     sq_f;
   logic [2*MANT_W-1:0]     sq_r;
   logic [MANT_W:0]         top_f;
   logic [MANT_W:0]         top_r;
   fmn_ctl_type             ctl_ff;
   logic signed [EXP_W-1:0] exp_ff;
   logic [MANT_W-1:0]       mant_f_in;
   logic [MANT_W-1:0]       mant_f_ff;
   logic [MANT_W-1:0]       mant_r_in;
   logic [MANT_W-1:0]       mant_r_ff;
   logic [LOG_BITS-1:0]     frac_f_in;
   logic [LOG_BITS-1:0]     frac_f_ff;
   logic [LOG_BITS-1:0]     frac_r_in;
   logic [LOG_BITS-1:0]     frac_r_ff;

   // Squaring a mantissa in [1,2) gives [1,4); a carry into the top bit
   // is the next log2 fraction bit and the mantissa is halved.
   always_comb begin
      sq_f      = up_mant_f * up_mant_f;
      sq_r      = up_mant_r * up_mant_r;
      top_f     = sq_f[2*MANT_W-1:MANT_W-1];
      top_r     = sq_r[2*MANT_W-1:MANT_W-1];
      mant_f_in = top_f[MANT_W] ? top_f[MANT_W:1] : top_f[MANT_W-1:0];
      mant_r_in = top_r[MANT_W] ? top_r[MANT_W:1] : top_r[MANT_W-1:0];
      frac_f_in = {up_frac_f[LOG_BITS-2:0], top_f[MANT_W]};
      frac_r_in = {up_frac_r[LOG_BITS-2:0], top_r[MANT_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exp_ff    <= up_exp;
         mant_f_ff <= mant_f_in;
         mant_r_ff <= mant_r_in;
         frac_f_ff <= frac_f_in;
         frac_r_ff <= frac_r_in;
      end
   end

   assign dn_ctl    = ctl_ff;
   assign dn_exp    = exp_ff;
   assign dn_mant_f = mant_f_ff;
   assign dn_mant_r = mant_r_ff;
   assign dn_frac_f = frac_f_ff;
   assign dn_frac_r = frac_r_ff;

endmodule

// File: rtl/fmn_note_map.sv
`timescale 1ns / 1ps
module fmn_note_map import fmn_pkg::*; #(
   parameter int LOG_BITS = FMN_LOG_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  fmn_ctl_type               up_ctl,
   input  logic signed [EXP_W-1:0]   up_exp,
   input  logic [LOG_BITS-1:0]       up_frac_f,
   input  logic [LOG_BITS-1:0]       up_frac_r,
   output logic                      dn_valid,
   output logic                      dn_note_valid,
   output logic signed [MIDI_W-1:0]  dn_midi,
   output logic [IDX_W-1:0]          dn_index,
   output logic signed [OCT_W-1:0]   dn_octave,
   output logic signed [CENTS_W-1:0] dn_cents
);

   localparam int SW     = LOG_BITS + 12;
   localparam int MW     = 11;
   localparam int RW     = LOG_BITS + 1;
   localparam int PW     = LOG_BITS + 16;
   localparam int VW     = 10;
   localparam int QW     = 7;
   localparam int RSH    = 15;
   localparam int QPW    = VW + 12;
   localparam int NSTAGE = 5;
   localparam int OCT_BIAS = 32;

   localparam logic signed [SW-1:0] S_BASE     = SW'(69) <<< LOG_BITS;
   localparam logic [SW-1:0]        S_HALF     = SW'(1) << (LOG_BITS - 1);
   localparam logic [PW-1:0]        P_HALF     = PW'(1) << (LOG_BITS - 1);
   localparam logic signed [PW-1:0] CENT_SCALE = PW'(10000);
   localparam logic [QPW-1:0]       RECIP12    = QPW'(2731);
   localparam logic signed [MW-1:0] V_OFFSET   = MW'(OCT_BIAS * 12);
   localparam logic signed [QW:0]   OCT_OFFSET = (QW + 1)'(OCT_BIAS + 1);

   fmn_ctl_type ctl_ff [NSTAGE];

   // Stage 1: semitone value with LOG_BITS fraction bits.
   logic signed [SW-1:0] d_w;
   logic signed [SW-1:0] s1_in;
   logic signed [SW-1:0] s1_ff;

   // Stage 2: nearest note, ties away from zero.
   logic [SW-1:0]        s_mag;
   logic [SW-1:0]        s_rnd;
   logic signed [MW-1:0] m_mag;
   logic signed [MW-1:0] midi2_in;
   logic signed [MW-1:0] midi2_ff;
   logic signed [SW-1:0] s2_ff;

   // Stage 3: remainder and offset note for the floor division.
   logic signed [SW-1:0] rem_w;
   logic signed [RW-1:0] rem3_in;
   logic signed [RW-1:0] rem3_ff;
   logic [VW-1:0]        v3_in;
   logic [VW-1:0]        v3_ff;
   logic signed [MW-1:0] midi3_ff;

   // Stage 4: products.
   logic signed [PW-1:0] cprod4_in;
   logic signed [PW-1:0] cprod4_ff;
   logic [QPW-1:0]       qprod4_in;
   logic [QPW-1:0]       qprod4_ff;
   logic [VW-1:0]        v4_ff;
   logic signed [MW-1:0] midi4_ff;

   // Stage 5: output register.
   logic [PW-1:0]             c_mag;
   logic [PW-1:0]             c_rnd;
   logic [CENTS_W-1:0]        c_q;
   logic [QW-1:0]             q_w;
   logic [VW-1:0]             r_w;
   logic signed [QW:0]        oct_w;
   logic                      note_valid_in;
   logic                      note_valid_ff;
   logic signed [MIDI_W-1:0]  midi_in;
   logic signed [MIDI_W-1:0]  midi_ff;
   logic [IDX_W-1:0]          index_in;
   logic [IDX_W-1:0]          index_ff;
   logic signed [OCT_W-1:0]   octave_in;
   logic signed [OCT_W-1:0]   octave_ff;
   logic signed [CENTS_W-1:0] cents_in;
   logic signed [CENTS_W-1:0] cents_ff;

   always_comb begin
      d_w   = (SW'(up_exp) <<< LOG_BITS) + SW'({1'b0, up_frac_f}) - SW'({1'b0, up_frac_r});
      s1_in = S_BASE + (d_w <<< 3) + (d_w <<< 2);
   end

   always_comb begin
      s_mag    = s1_ff[SW-1] ? SW'(-s1_ff) : SW'(s1_ff);
      s_rnd    = s_mag + S_HALF;
      m_mag    = s_rnd[LOG_BITS +: MW];
      midi2_in = s1_ff[SW-1] ? -m_mag : m_mag;
   end

   always_comb begin
      rem_w   = s2_ff - (SW'(midi2_ff) <<< LOG_BITS);
      rem3_in = rem_w[RW-1:0];
      v3_in   = VW'(midi2_ff + V_OFFSET);
   end

   always_comb begin
      cprod4_in = PW'(rem3_ff) * CENT_SCALE;
      qprod4_in = QPW'(v3_ff) * RECIP12;
   end

   always_comb begin
      c_mag         = cprod4_ff[PW-1] ? PW'(-cprod4_ff) : PW'(cprod4_ff);
      c_rnd         = c_mag + P_HALF;
      c_q           = c_rnd[LOG_BITS +: CENTS_W];
      q_w           = qprod4_ff[RSH +: QW];
      r_w           = v4_ff - ((VW'(q_w) << 3) + (VW'(q_w) << 2));
      oct_w         = $signed({1'b0, q_w}) - OCT_OFFSET;
      note_valid_in = !ctl_ff[3].zero;
      if (ctl_ff[3].zero) begin
         midi_in   = '0;
         index_in  = '0;
         octave_in = '0;
         cents_in  = '0;
      end else begin
         midi_in   = midi4_ff[MIDI_W-1:0];
         index_in  = r_w[IDX_W-1:0];
         octave_in = oct_w[OCT_W-1:0];
         cents_in  = cprod4_ff[PW-1] ? -$signed(c_q) : $signed(c_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTAGE; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= up_ctl;
         for (int k = 1; k < NSTAGE; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff         <= s1_in;
         s2_ff         <= s1_ff;
         midi2_ff      <= midi2_in;
         rem3_ff       <= rem3_in;
         v3_ff         <= v3_in;
         midi3_ff      <= midi2_ff;
         cprod4_ff     <= cprod4_in;
         qprod4_ff     <= qprod4_in;
         v4_ff         <= v3_ff;
         midi4_ff      <= midi3_ff;
         note_valid_ff <= note_valid_in;
         midi_ff       <= midi_in;
         index_ff      <= index_in;
         octave_ff     <= octave_in;
         cents_ff      <= cents_in;
      end
   end

   assign dn_valid      = ctl_ff[NSTAGE-1].valid;
   assign dn_note_valid = note_valid_ff;
   assign dn_midi       = midi_ff;
   assign dn_index      = index_ff;
   assign dn_octave     = octave_ff;
   assign dn_cents      = cents_ff;

endmodule

// File: rtl/frequency_to_midi_note.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_ch    in         freq_q16
// rsp_ch    out        note_valid, midi_note, pitch_class, octave_number, cents_deviation
// csr       in         csr_wdata, written when csr_we is high
//
// One request is accepted every cycle while no response is stalled at the output.
// The pipeline has one mantissa squaring stage per log2 fraction bit.
// Reset is synchronous and clears all valid bits; the A4 reference returns to 440 Hz.
// While a response waits at the output, the whole pipeline holds in place.
module frequency_to_midi_note import fmn_pkg::*; #(
   parameter int LOG_BITS = FMN_LOG_BITS
) (
   input  logic             clock,
   input  logic             reset,
   fmn_req_if.sink          req_ch,
   fmn_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [REF_W-1:0] csr_wdata
);

   logic [REF_W-1:0] a4_ff;
   logic             en;

   fmn_ctl_type             ctl_w    [LOG_BITS+1];
   logic signed [EXP_W-1:0] exp_w    [LOG_BITS+1];
   logic [MANT_W-1:0]       mant_f_w [LOG_BITS+1];
   logic [MANT_W-1:0]       mant_r_w [LOG_BITS+1];
   logic [LOG_BITS-1:0]     frac_f_w [LOG_BITS+1];
   logic [LOG_BITS-1:0]     frac_r_w [LOG_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         a4_ff <= REF_RESET;
      end else if (csr_we) begin
         a4_ff <= csr_wdata;
      end
   end

   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;
   assign frac_f_w[0]  = '0;
   assign frac_r_w[0]  = '0;

   fmn_normalize u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .up_valid  (req_ch.valid),
      .up_freq   (req_ch.freq_q16),
      .up_a4     (a4_ff),
      .dn_ctl    (ctl_w[0]),
      .dn_exp    (exp_w[0]),
      .dn_mant_f (mant_f_w[0]),
      .dn_mant_r (mant_r_w[0])
   );

   for (genvar g = 0; g < LOG_BITS; g++) begin : g_log
      fmn_log_stage #(.LOG_BITS(LOG_BITS)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .up_ctl    (ctl_w[g]),
         .up_exp    (exp_w[g]),
         .up_mant_f (mant_f_w[g]),
         .up_mant_r (mant_r_w[g]),
         .up_frac_f (frac_f_w[g]),
         .up_frac_r (frac_r_w[g]),
         .dn_ctl    (ctl_w[g+1]),
         .dn_exp    (exp_w[g+1]),
         .dn_mant_f (mant_f_w[g+1]),
         .dn_mant_r (mant_r_w[g+1]),
         .dn_frac_f (frac_f_w[g+1]),
         .dn_frac_r (frac_r_w[g+1])
      );
   end

   fmn_note_map #(.LOG_BITS(LOG_BITS)) u_map (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .up_ctl        (ctl_w[LOG_BITS]),
      .up_exp        (exp_w[LOG_BITS]),
      .up_frac_f     (frac_f_w[LOG_BITS]),
      .up_frac_r     (frac_r_w[LOG_BITS]),
      .dn_valid      (rsp_ch.valid),
      .dn_note_valid (rsp_ch.note_valid),
      .dn_midi       (rsp_ch.midi_note),
      .dn_index      (rsp_ch.pitch_class),
      .dn_octave     (rsp_ch.octave_number),
      .dn_cents      (rsp_ch.cents_deviation)
   );

   // A response without a note carries all-zero fields.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.note_valid) |->
         (rsp_ch.midi_note == '0) && (rsp_ch.pitch_class == '0) &&
         (rsp_ch.octave_number == '0) && (rsp_ch.cents_deviation == '0))
      else $error("note fields not cleared for a zero request");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.note_valid) |-> (rsp_ch.pitch_class <= IDX_W'(11)))
      else $error("note index out of range");

   a_cents_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.note_valid) |->
         (rsp_ch.cents_deviation >= -CENTS_W'(5000)) &&
         (rsp_ch.cents_deviation <= CENTS_W'(5000)))
      else $error("cents deviation beyond half a semitone");

   // The pipeline moves only when the output slot is free or being drained.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid && $stable(ctl_w[LOG_BITS])))
      else $error("pipeline advanced while the response was stalled");

endmodule

// File: bench/frequency_to_midi_note_checker.sv
`timescale 1ns / 1ps
module frequency_to_midi_note_checker import fmn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   fmn_req_if               req_ch,
   fmn_rsp_if               rsp_ch,
   input  logic             csr_we,
   input  logic [REF_W-1:0] csr_wdata,
   output int               mismatches,
   output int               pending_notes
);

   localparam int           FREQ_FRAC = 16;
   localparam longint       SCALE     = 64'sd1 <<< FMN_LOG_BITS;
   localparam longint       HALF      = SCALE / 2;

   typedef struct packed {
      logic                      note_valid;
      logic signed [MIDI_W-1:0]  midi_note;
      logic [IDX_W-1:0]          pitch_class;
      logic signed [OCT_W-1:0]   octave_number;
      logic signed [CENTS_W-1:0] cents_deviation;
   } note_type;

   note_type         expected_notes [$];
   note_type         seen_note;
   note_type         wanted_note;
   logic [REF_W-1:0] a4_pitch;

   function automatic longint log2_fixed(input logic [FREQ_W-1:0] x);
      int                      lead;
      logic [63:0]             mant;
      logic [63:0]             square;
      logic [FMN_LOG_BITS-1:0] frac;
      lead = 0;
      for (int i = 0; i < FREQ_W; i++) begin
         if (x[i]) begin
            lead = i;
         end
      end
      mant = 64'(x) << (31 - lead);
      frac = '0;
      for (int i = 0; i < FMN_LOG_BITS; i++) begin
         square = mant * mant;
         mant = square >> 31;
         frac = frac << 1;
         if (mant[32]) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return longint'(lead - FREQ_FRAC) * SCALE + longint'(frac);
   endfunction

   function automatic longint round_to_unit(input longint v);
      if (v >= 0) begin
         return (v + HALF) / SCALE;
      end
      return -((HALF - v) / SCALE);
   endfunction

   function automatic note_type note_of_frequency(input logic [FREQ_W-1:0] freq,
                                                  input logic [REF_W-1:0] a4);
      note_type note;
      longint   semitones;
      longint   midi;
      longint   rem;
      longint   cents;
      longint   shifted;
      note = '0;
      if (freq == '0 || a4 == '0) begin
         return note;
      end
      semitones = 69 * SCALE + 12 * (log2_fixed(freq) - log2_fixed(FREQ_W'(a4)));
      midi = round_to_unit(semitones);
      rem = semitones - midi * SCALE;
      cents = round_to_unit(rem * 10000);
      // Offset by a multiple of 12 so that the division floors.
      shifted = midi + 12 * 4096;
      note.note_valid = 1'b1;
      note.midi_note = MIDI_W'(midi);
      note.pitch_class = IDX_W'(shifted % 12);
      note.octave_number = OCT_W'(shifted / 12 - 4096 - 1);
      note.cents_deviation = CENTS_W'(cents);
      return note;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_notes.delete();
         a4_pitch = REF_RESET;
         mismatches = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_note = '{rsp_ch.note_valid, rsp_ch.midi_note, rsp_ch.pitch_class,
                          rsp_ch.octave_number, rsp_ch.cents_deviation};
            if (expected_notes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Response with no request outstanding: valid=%0d midi=%0d",
                           seen_note.note_valid, $signed(seen_note.midi_note));
               end
            end else begin
               wanted_note = expected_notes.pop_front();
               if (seen_note.note_valid !== wanted_note.note_valid
                   || seen_note.midi_note !== wanted_note.midi_note
                   || seen_note.pitch_class !== wanted_note.pitch_class
                   || seen_note.octave_number !== wanted_note.octave_number
                   || seen_note.cents_deviation !== wanted_note.cents_deviation) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch at %0t ns", $time);
                     $display("  expected valid=%0d midi=%0d index=%0d octave=%0d cents=%0d",
                              wanted_note.note_valid, $signed(wanted_note.midi_note),
                              wanted_note.pitch_class, $signed(wanted_note.octave_number),
                              $signed(wanted_note.cents_deviation));
                     $display("  actual   valid=%0d midi=%0d index=%0d octave=%0d cents=%0d",
                              seen_note.note_valid, $signed(seen_note.midi_note),
                              seen_note.pitch_class, $signed(seen_note.octave_number),
                              $signed(seen_note.cents_deviation));
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_notes.push_back(note_of_frequency(req_ch.freq_q16, a4_pitch));
         end
         if (csr_we) begin
            a4_pitch = csr_wdata;
         end
      end
      pending_notes <= expected_notes.size();
   end

endmodule

// File: bench/frequency_to_midi_note_test.sv
`timescale 1ns / 1ps
module frequency_to_midi_note_test;
   import fmn_pkg::*;

   localparam int               LATENCY  = FMN_LOG_BITS + 6;
   localparam logic [REF_W-1:0] A4_LOW   = 25'd26214400;
   localparam logic [REF_W-1:0] A4_HIGH  = 25'd31457280;
   localparam logic [REF_W-1:0] A4_MAX   = 25'h1FFFFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [REF_W-1:0] csr_wdata = '0;
   bit               idling = 1'b1;
   int               stall_left = 0;
   int               mismatches;
   int               pending_notes;

   logic [FREQ_W-1:0] directed_freqs [15] = '{
      32'd0, 32'd1, 32'hFFFFFFFF, 32'd28835840, 32'd14417920, 32'd57671680,
      32'h00010000, 32'h80000000, 32'h7FFFFFFF, 32'd2, 32'h0000FFFF,
      32'd27212777, 32'd29680804, 32'd1071618, 32'd535808
   };

   fmn_req_if req_ch ();
   fmn_rsp_if rsp_ch ();

   frequency_to_midi_note i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   frequency_to_midi_note_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending_notes (pending_notes)
   );

   always #10 clock = ~clock;

   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready = 1'b0;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   function automatic logic [FREQ_W-1:0] random_frequency();
      logic [FREQ_W-1:0] f;
      case ($urandom_range(0, 19))
         0: f = '0;
         1, 2, 3: f = $urandom;
         4, 5, 6: f = $urandom >> $urandom_range(0, 31);
         7: f = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
         default: f = (32'($urandom_range(16, 8000)) << 16) | ($urandom & 32'hFFFF);
      endcase
      return f;
   endfunction

   task automatic send_frequency(input logic [FREQ_W-1:0] freq);
      int gap;
      gap = 0;
      if (idling && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 6);
      end
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.freq_q16 = freq;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_notes != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic set_reference(input logic [REF_W-1:0] value);
      drain();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.freq_q16 = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_freqs[i]) begin
         send_frequency(directed_freqs[i]);
      end
      // A zero reference must suppress every note.
      set_reference('0);
      send_frequency(32'd0);
      send_frequency(32'd1);
      send_frequency(32'd28835840);
      send_frequency(32'hFFFFFFFF);
      // References far outside the musical range wrap the signed fields.
      set_reference(A4_MAX);
      send_frequency(32'd1);
      send_frequency(32'hFFFFFFFF);
      set_reference(25'd1);
      send_frequency(32'hFFFFFFFF);
      send_frequency(32'd1);

      for (int phase = 0; phase < 6; phase++) begin
         idling = (phase != 2) && (phase != 5);
         case (phase)
            0: set_reference(A4_LOW);
            1: set_reference(A4_HIGH);
            3: set_reference(REF_W'($urandom) & A4_MAX);
            5: set_reference(REF_RESET);
            default: set_reference(REF_W'($urandom_range(A4_LOW, A4_HIGH)));
         endcase
         for (int n = 0; n < 105; n++) begin
            if (n == 50) begin
               drain();
            end
            send_frequency(random_frequency());
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("** frequency_to_midi_note: PASSED **");
      end else begin
         $display("** frequency_to_midi_note: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** frequency_to_midi_note: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
rtl/fmn_pkg.sv
rtl/fmn_req_if.sv
rtl/fmn_rsp_if.sv
rtl/fmn_normalize.sv
rtl/fmn_log_stage.sv
rtl/fmn_note_map.sv
rtl/frequency_to_midi_note.sv
bench/frequency_to_midi_note_checker.sv
bench/frequency_to_midi_note_test.sv
